/* rtl/stdc_pkg.sv */
// ----------------------------------------------------------------------------
// stdc_pkg
// Shared types and constants of the step timer divider calculator.
// ----------------------------------------------------------------------------
package stdc_pkg;

  // defaults of the top level parameters
  localparam int CLOCK_HZ_DEF     = 8000000;
  localparam int MAX_PRESCALE_DEF = 16;

  // field widths
  localparam int RPM_W   = 8;
  localparam int STEPS_W = 16;
  localparam int CODE_W  = 5;
  localparam int CMP_W   = 8;

  // stream word widths
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // arithmetic constants
  localparam longint unsigned SEC_PER_MIN  = 64'd60;
  localparam longint unsigned COARSE_SCALE = 64'd256;
  localparam int              CODE_MAX     = 16;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV_A,
    ST_DIV_B,
    ST_PRESC,
    ST_DIV_C,
    ST_DIV_D,
    ST_FINISH
  } stdc_state_e;

  // dividend source of a division
  typedef enum logic [1:0] {
    SRC_COARSE,
    SRC_QUOT,
    SRC_SHIFT
  } stdc_src_e;

  // divisor source of a division
  typedef enum logic {
    DVS_STEPS,
    DVS_RPM
  } stdc_dvs_e;

  // commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      div_start;
    stdc_src_e src;
    stdc_dvs_e dvs;
    logic      presc_step;
    logic      out_load;
  } stdc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_done;
    logic off;
    logic presc_more;
  } stdc_status_t;

endpackage

/* rtl/stdc_div.sv */
// ----------------------------------------------------------------------------
// stdc_div
// Restoring divider, one quotient bit per cycle, divisor up to 16 bits.
// ----------------------------------------------------------------------------
module stdc_div
  import stdc_pkg::*;
#(
  parameter int DW = 29
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DW-1:0]      dividend_i,
  input  logic [STEPS_W-1:0] divisor_i,
  output logic [DW-1:0]      quotient_o,
  output logic               done_o
);

  localparam int CNT_W = $clog2(DW);

  logic [STEPS_W-1:0] rem_q, rem_d;
  logic [STEPS_W-1:0] dvs_q;
  logic [DW-1:0]      quo_q, quo_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEPS_W:0]   rem_sh;
  logic [STEPS_W:0]   rem_sub;
  logic               fits;

  // one shift and subtract step
  always_comb begin
    rem_sh  = {rem_q, quo_q[DW-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = (rem_sh >= {1'b0, dvs_q});
    rem_d   = fits ? rem_sub[STEPS_W-1:0] : rem_sh[STEPS_W-1:0];
    quo_d   = {quo_q[DW-2:0], fits};
  end

  // control of the iteration
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DW - 1);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* rtl/stdc_dpath.sv */
// ----------------------------------------------------------------------------
// stdc_dpath
// Operand registers, dividend and divisor selection, prescaler search and
// result registers around the shared divider.
// ----------------------------------------------------------------------------
module stdc_dpath
  import stdc_pkg::*;
#(
  parameter int CLOCK_HZ     = CLOCK_HZ_DEF,
  parameter int MAX_PRESCALE = MAX_PRESCALE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stdc_cmd_t          cmd_i,
  output stdc_status_t       status_o,
  input  logic [RPM_W-1:0]   speed_rpm_i,
  input  logic [STEPS_W-1:0] steps_per_turn_i,
  output logic [CODE_W-1:0]  prescale_code_o,
  output logic [CMP_W-1:0]   compare_value_o
);

  localparam longint unsigned TICKS = 64'(CLOCK_HZ) * SEC_PER_MIN;
  localparam int              DW    = $clog2(TICKS + 1);
  localparam longint unsigned COARSE = TICKS / COARSE_SCALE;

  logic [RPM_W-1:0]   rpm_q;
  logic [STEPS_W-1:0] spt_q;
  logic               off_q;
  logic [CODE_W-1:0]  code_q;
  logic [CODE_W-1:0]  out_code_q;
  logic [CMP_W-1:0]   out_cmp_q;
  logic [DW-1:0]      dividend;
  logic [STEPS_W-1:0] divisor;
  logic [DW-1:0]      quotient;
  logic               div_done;
  logic [DW-1:0]      pow;
  logic [CMP_W-1:0]   cmp_next;

  // operands of the next division
  always_comb begin
    unique case (cmd_i.src)
      SRC_COARSE: dividend = DW'(COARSE);
      SRC_QUOT:   dividend = quotient;
      SRC_SHIFT:  dividend = DW'(TICKS) >> code_q;
      default:    dividend = quotient;
    endcase
    unique case (cmd_i.dvs)
      DVS_STEPS: divisor = spt_q;
      DVS_RPM:   divisor = {{(STEPS_W-RPM_W){1'b0}}, rpm_q};
      default:   divisor = spt_q;
    endcase
  end

  stdc_div #(
    .DW(DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // prescaler search: divisor is two to the power of the code
  assign pow      = DW'(1) << code_q;
  assign cmp_next = quotient[CMP_W-1:0] - 1'b1;

  assign status_o.div_done   = div_done;
  assign status_o.off        = off_q;
  assign status_o.presc_more = (pow < quotient) && (code_q < CODE_W'(MAX_PRESCALE));

  // input capture and prescaler code
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rpm_q  <= speed_rpm_i;
      spt_q  <= steps_per_turn_i;
      off_q  <= (speed_rpm_i == '0) || (steps_per_turn_i == '0);
      code_q <= CODE_W'(1);
    end else if (cmd_i.presc_step) begin
      code_q <= code_q + 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (off_q) begin
        out_code_q <= '0;
        out_cmp_q  <= '0;
      end else begin
        out_code_q <= code_q;
        out_cmp_q  <= cmp_next;
      end
    end
  end

  assign prescale_code_o = out_code_q;
  assign compare_value_o = out_cmp_q;

endmodule

/* rtl/stdc_ctrl.sv */
// ----------------------------------------------------------------------------
// stdc_ctrl
// Sequencer of the four divisions and the prescaler search, plus the
// output valid flag.
// ----------------------------------------------------------------------------
module stdc_ctrl
  import stdc_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  stdc_status_t status_i,
  output stdc_cmd_t    cmd_o
);

  stdc_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load: 1'b0, div_start: 1'b0, src: SRC_COARSE, dvs: DVS_STEPS,
                   presc_step: 1'b0, out_load: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.off) begin
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.src       = SRC_COARSE;
          cmd_o.dvs       = DVS_STEPS;
          state_d         = ST_DIV_A;
        end
      end
      ST_DIV_A: begin
        if (status_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.src       = SRC_QUOT;
          cmd_o.dvs       = DVS_RPM;
          state_d         = ST_DIV_B;
        end
      end
      ST_DIV_B: begin
        if (status_i.div_done) begin
          state_d = ST_PRESC;
        end
      end
      ST_PRESC: begin
        if (status_i.presc_more) begin
          cmd_o.presc_step = 1'b1;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.src       = SRC_SHIFT;
          cmd_o.dvs       = DVS_STEPS;
          state_d         = ST_DIV_C;
        end
      end
      ST_DIV_C: begin
        if (status_i.div_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.src       = SRC_QUOT;
          cmd_o.dvs       = DVS_RPM;
          state_d         = ST_DIV_D;
        end
      end
      ST_DIV_D: begin
        if (status_i.div_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/step_timer_divider_calc_core.sv */
// ----------------------------------------------------------------------------
// step_timer_divider_calc_core
// Turns a shaft speed and a step count per turn into a timer prescaler code
// and an 8-bit compare value.
// ----------------------------------------------------------------------------
// One result per input transaction. An item with speed or steps zero goes
// from the load state straight to the finish state and gives code 0, compare 0.
// Any other item runs four divisions one after another on a single restoring
// divider, W = clog2(CLOCK_HZ*60+1) bits wide (29 at 8 MHz), that produces one
// quotient bit per cycle, with a prescaler search of at most MAX_PRESCALE-1
// steps between the second and third division. The next item is taken once the
// previous result sits in the output register, which holds it until the
// consumer takes it.
module step_timer_divider_calc_core
  import stdc_pkg::*;
#(
  parameter int CLOCK_HZ     = CLOCK_HZ_DEF,
  parameter int MAX_PRESCALE = MAX_PRESCALE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // speed_rpm[7:0], steps_per_turn[23:8]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata    // prescale_code[4:0], compare_value[12:5],
                                                // zero[15:13]
);

  stdc_cmd_t          cmd;
  stdc_status_t       status;
  logic [CODE_W-1:0]  prescale_code;
  logic [CMP_W-1:0]   compare_value;

  stdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stdc_dpath #(
    .CLOCK_HZ     (CLOCK_HZ),
    .MAX_PRESCALE (MAX_PRESCALE)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .speed_rpm_i      (s_axis_tdata[RPM_W-1:0]),
    .steps_per_turn_i (s_axis_tdata[RPM_W+STEPS_W-1:RPM_W]),
    .prescale_code_o  (prescale_code),
    .compare_value_o  (compare_value)
  );

  // pack result fields from the lowest bit up
  assign m_axis_tdata = {{(OUT_DATA_W-CODE_W-CMP_W){1'b0}}, compare_value, prescale_code};

endmodule

/* rtl/stdc_checker.sv */
// ----------------------------------------------------------------------------
// stdc_checker
// Port level checks of the step timer divider calculator, bound to the top.
// ----------------------------------------------------------------------------
module stdc_checker
  import stdc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // a stalled result stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

  // one item at a time: no new transaction right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while previous item in work");

  // code in range, and a zero code comes with a zero compare value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[CODE_W-1:0] <= CODE_W'(CODE_MAX)) &&
                      ((m_axis_tdata[CODE_W-1:0] != '0) ||
                       (m_axis_tdata[CODE_W+CMP_W-1:CODE_W] == '0)))
    else $error("inconsistent result fields");

endmodule

bind step_timer_divider_calc_core stdc_checker u_stdc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
